// ----- hdl/lae_pkg.sv -----
// Package with shared constants, phase codes and controller state codes of the envelope block.
package lae_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int APB_DATA_WIDTH  = 32;
  localparam int APB_ADDR_WIDTH  = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_SUSTAIN = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_PUT  = 2'd3
  } ctl_state_t;

endpackage

// ----- hdl/lae_if.sv -----
// Request channel interfaces for the gate input and the envelope output.
interface lae_gate_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink   (input valid, input gate, output ready);
endinterface

interface lae_env_if #(
  parameter int LEVEL_WIDTH = lae_pkg::LEVEL_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [LEVEL_WIDTH-1:0] level;
  logic [2:0]             phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

// ----- hdl/linear_adsr_envelope.sv -----
// Linear ADSR envelope generator with a bit-serial multiply and divide datapath.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------
//  tick    | in  | valid / ready     | gate (1 bit)
//  env     | out | valid / ready     | level (LEVEL_WIDTH), phase (3 bits)
//  apb     | in  | psel/penable/...  | four setup registers, 32-bit data
//
// A ramp tick (attack, decay or release before its end) runs from request to the
// next request through the accept state, a shift-and-add multiply and a restoring
// division, one bit per cycle each, and the state that loads the output register.
// Phase-end, sustain and idle ticks skip the multiply and divide and go straight
// from the accept state to the load state.
// rst is synchronous and active high; it clears the registers, phase, count and gate.
// A finished result sits in the output register while the next request is
// accepted; the controller stalls in its final state only if that register is
// still full when the next result is ready.
module linear_adsr_envelope #(
  parameter int COUNT_WIDTH = lae_pkg::COUNT_WIDTH_DEF,
  parameter int LEVEL_WIDTH = lae_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  lae_gate_if.sink                           tick,
  lae_env_if.source                          env,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lae_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [lae_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [lae_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import lae_pkg::*;

  localparam int ACC_W  = COUNT_WIDTH + LEVEL_WIDTH;
  localparam int STEP_W = (LEVEL_WIDTH > 1) ? $clog2(LEVEL_WIDTH) : 1;
  localparam logic [LEVEL_WIDTH-1:0] FULL     = '1;
  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(LEVEL_WIDTH - 1);

  // Setup registers, written over the APB port; the user must write them only while the block is idle (not enforced).
  logic [COUNT_WIDTH-1:0] attack_samples;
  logic [COUNT_WIDTH-1:0] decay_samples;
  logic [COUNT_WIDTH-1:0] release_samples;
  logic [LEVEL_WIDTH-1:0] sustain_level;

  // Envelope state.
  phase_t                 phase;
  logic [COUNT_WIDTH-1:0] count;
  logic                   prev_gate;

  // Controller.
  ctl_state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic in_rdy, mul_en, div_en, put_en;

  // Serial datapath: multiplicand, multiplier bits MSB first, product, divisor,
  // partial remainder, and the dividend low bits that turn into the quotient.
  logic [COUNT_WIDTH-1:0] mul_x;
  logic [LEVEL_WIDTH-1:0] mul_m;
  logic [ACC_W-1:0]       acc;
  logic [COUNT_WIDTH-1:0] div_d;
  logic [COUNT_WIDTH-1:0] rem;
  logic [LEVEL_WIDTH-1:0] quo;
  logic                   invert;
  logic [LEVEL_WIDTH-1:0] res_level;
  phase_t                 res_phase;

  // Output register.
  logic                   out_valid;
  logic [LEVEL_WIDTH-1:0] out_level;
  phase_t                 out_phase;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access cycle; reads are a mux.
  // ---------------------------------------------------------------------------
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= '0;
      decay_samples   <= '0;
      release_samples <= '0;
      sustain_level   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK:  attack_samples  <= pwdata[COUNT_WIDTH-1:0];
        REG_DECAY:   decay_samples   <= pwdata[COUNT_WIDTH-1:0];
        REG_RELEASE: release_samples <= pwdata[COUNT_WIDTH-1:0];
        REG_SUSTAIN: sustain_level   <= pwdata[LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:  prdata = APB_DATA_WIDTH'(attack_samples);
      REG_DECAY:   prdata = APB_DATA_WIDTH'(decay_samples);
      REG_RELEASE: prdata = APB_DATA_WIDTH'(release_samples);
      REG_SUSTAIN: prdata = APB_DATA_WIDTH'(sustain_level);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick decode. An edge on the gate restarts attack or release with a cleared
  // count; then the phase either ends on this tick with a fixed level, holds a
  // fixed level, or needs a ramp value x * m / L from the serial unit, inverted in decay.
  // ---------------------------------------------------------------------------
  logic                   rise, fall;
  phase_t                 ph_e, ph_n;
  logic [COUNT_WIDTH-1:0] cnt_e, cnt_n;
  logic                   advance, immediate, inv_n;
  logic [LEVEL_WIDTH-1:0] imm_level, m_n;
  logic [COUNT_WIDTH-1:0] x_n, d_n;

  assign rise  = tick.gate & ~prev_gate;
  assign fall  = ~tick.gate & prev_gate;
  assign ph_e  = rise ? PH_ATTACK : (fall ? PH_RELEASE : phase);
  assign cnt_e = (rise | fall) ? '0 : count;

  always_comb begin
    ph_n      = ph_e;
    advance   = 1'b1;
    immediate = 1'b0;
    imm_level = '0;
    inv_n     = 1'b0;
    x_n       = cnt_e;
    m_n       = FULL;
    d_n       = attack_samples;
    unique case (ph_e)
      PH_ATTACK: begin
        if (cnt_e >= attack_samples) begin
          ph_n      = PH_DECAY;
          advance   = 1'b0;
          immediate = 1'b1;
          imm_level = FULL;
        end
      end
      PH_DECAY: begin
        d_n   = decay_samples;
        m_n   = FULL - sustain_level;
        inv_n = 1'b1;
        if (cnt_e >= decay_samples) begin
          ph_n      = PH_SUSTAIN;
          advance   = 1'b0;
          immediate = 1'b1;
          imm_level = sustain_level;
        end
      end
      PH_SUSTAIN: begin
        immediate = 1'b1;
        imm_level = sustain_level;
      end
      PH_RELEASE: begin
        d_n = release_samples;
        m_n = sustain_level;
        x_n = release_samples - cnt_e;
        if (cnt_e >= release_samples) begin
          ph_n      = PH_IDLE;
          advance   = 1'b0;
          immediate = 1'b1;
        end
      end
      default: begin
        ph_n      = PH_IDLE;
        immediate = 1'b1;
      end
    endcase
  end

  // The count clears when attack or decay ends, and saturates instead of wrapping.
  always_comb begin
    if (!advance && (ph_e != PH_RELEASE)) begin
      cnt_n = '0;
    end else if (advance && (cnt_e != '1)) begin
      cnt_n = cnt_e + 1'b1;
    end else begin
      cnt_n = cnt_e;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller: next state and outputs in separate blocks.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick.valid) begin
          state_next = immediate ? ST_PUT : ST_MUL;
        end
      end
      ST_MUL: begin
        if (step == LAST_STEP) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == LAST_STEP) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid || env.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy = 1'b0;
    mul_en = 1'b0;
    div_en = 1'b0;
    put_en = 1'b0;
    unique case (state)
      ST_IDLE: in_rdy = 1'b1;
      ST_MUL:  mul_en = 1'b1;
      ST_DIV:  div_en = 1'b1;
      ST_PUT:  put_en = !out_valid || env.ready;
      default: ;
    endcase
  end

  assign tick.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      phase     <= PH_IDLE;
      count     <= '0;
      prev_gate <= 1'b0;
    end else begin
      state <= state_next;
      if ((mul_en || div_en) && step != LAST_STEP) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      // The tick's effect on the envelope state is known at acceptance.
      if (tick.valid && in_rdy) begin
        phase     <= ph_n;
        count     <= cnt_n;
        prev_gate <= tick.gate;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Serial datapath. Multiply: acc = 2*acc + (bit ? x : 0), multiplier MSB
  // first. Divide: the product is below L * 2^LEVEL_WIDTH, so its high part
  // starts as the remainder and each step shifts one low bit in and produces
  // one quotient bit.
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]     prod;
  logic [COUNT_WIDTH:0] trial;
  logic                 qbit;

  assign prod  = (acc << 1) + (mul_m[LEVEL_WIDTH-1] ? ACC_W'(mul_x) : ACC_W'(0));
  assign trial = {rem, quo[LEVEL_WIDTH-1]};
  assign qbit  = trial >= {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (tick.valid && in_rdy) begin
      mul_x     <= x_n;
      mul_m     <= m_n;
      div_d     <= d_n;
      invert    <= inv_n;
      acc       <= '0;
      res_level <= imm_level;
      res_phase <= ph_n;
    end
    if (mul_en) begin
      acc   <= prod;
      mul_m <= mul_m << 1;
      if (step == LAST_STEP) begin
        rem <= prod[ACC_W-1:LEVEL_WIDTH];
        quo <= prod[LEVEL_WIDTH-1:0];
      end
    end
    if (div_en) begin
      rem <= qbit ? COUNT_WIDTH'(trial - {1'b0, div_d}) : trial[COUNT_WIDTH-1:0];
      quo <= {quo[LEVEL_WIDTH-2:0], qbit};
      if (step == LAST_STEP) begin
        res_level <= invert ? FULL - {quo[LEVEL_WIDTH-2:0], qbit}
                            : {quo[LEVEL_WIDTH-2:0], qbit};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_en) begin
      out_valid <= 1'b1;
    end else if (env.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      out_level <= res_level;
      out_phase <= res_phase;
    end
  end

  assign env.valid = out_valid;
  assign env.level = out_level;
  assign env.phase = out_phase;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> state != ST_IDLE)
    else $error("controller stayed idle after accepting a request");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < div_d)
    else $error("partial remainder reached the divisor");

  a_load_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_PUT)
    else $error("output register filled outside the put state");

  a_put_fills_output: assert property (@(posedge clk) disable iff (rst)
    put_en |=> out_valid)
    else $error("result was not held in the output register");

endmodule

// ----- tb/lae_envelope_checker.sv -----
// Checker for the envelope block: tracks register writes, predicts each tick and compares.
`timescale 1ns / 1ps

module lae_envelope_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  input  logic                                tick_ready,
  input  logic                                tick_gate,
  input  logic                                env_valid,
  input  logic                                env_ready,
  input  logic [lae_pkg::LEVEL_WIDTH_DEF-1:0] env_level,
  input  logic [2:0]                          env_phase,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [lae_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [lae_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output int                                  mismatch_count,
  output int                                  pending_results
);
  import lae_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam int LW = LEVEL_WIDTH_DEF;
  localparam logic [LW-1:0] LEVEL_FULL = {LW{1'b1}};
  localparam logic [CW-1:0] COUNT_MAX  = {CW{1'b1}};

  typedef struct {
    logic [LW-1:0] level;
    phase_t        phase;
  } env_sample_t;

  env_sample_t predicted_samples[$];

  // Register copies and envelope state of the prediction.
  logic [CW-1:0] attack_len, decay_len, release_len;
  logic [LW-1:0] sustain_lvl;
  phase_t        env_state;
  logic [CW-1:0] tick_cnt;
  logic          last_gate;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: envelope mismatch on %s: got %0d, predicted %0d", $realtime, what, got,
             want);
    mismatch_count++;
  endtask

  // Advance the envelope by one sample tick and return the sample it produces.
  task automatic step_envelope(input logic g, output env_sample_t res);
    logic [CW-1:0] c;
    logic [63:0]   num;
    logic [63:0]   den;
    logic          hold;
    hold      = 1'b0;
    res.level = '0;
    if (g && !last_gate) begin
      env_state = PH_ATTACK;
      tick_cnt  = '0;
    end
    if (!g && last_gate) begin
      env_state = PH_RELEASE;
      tick_cnt  = '0;
    end
    c = tick_cnt;
    case (env_state)
      PH_ATTACK: begin
        if (c >= attack_len) begin
          env_state = PH_DECAY;
          tick_cnt  = '0;
          res.level = LEVEL_FULL;
          hold      = 1'b1;
        end else begin
          num       = 64'(c) * 64'(LEVEL_FULL);
          den       = 64'(attack_len);
          res.level = LW'(num / den);
        end
      end
      PH_DECAY: begin
        if (c >= decay_len) begin
          env_state = PH_SUSTAIN;
          tick_cnt  = '0;
          res.level = sustain_lvl;
          hold      = 1'b1;
        end else begin
          num       = 64'(LEVEL_FULL - sustain_lvl) * 64'(c);
          den       = 64'(decay_len);
          res.level = LEVEL_FULL - LW'(num / den);
        end
      end
      PH_SUSTAIN: begin
        res.level = sustain_lvl;
      end
      PH_RELEASE: begin
        if (c >= release_len) begin
          env_state = PH_IDLE;
          hold      = 1'b1;
        end else begin
          num       = 64'(sustain_lvl) * 64'(release_len - c);
          den       = 64'(release_len);
          res.level = LW'(num / den);
        end
      end
      default: begin
        env_state = PH_IDLE;
      end
    endcase
    if (!hold && tick_cnt != COUNT_MAX) tick_cnt++;
    last_gate = g;
    res.phase = env_state;
  endtask

  always @(posedge clk) begin
    env_sample_t want;
    env_sample_t got;
    if (rst) begin
      predicted_samples.delete();
      attack_len  = '0;
      decay_len   = '0;
      release_len = '0;
      sustain_lvl = '0;
      env_state   = PH_IDLE;
      tick_cnt    = '0;
      last_gate   = 1'b0;
    end else begin
      // A result can never belong to a request taken at the same edge.
      if (env_valid && env_ready) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch("unexpected result", env_level, -1);
        end else begin
          want = predicted_samples.pop_front();
          if (env_level !== want.level) report_mismatch("level", env_level, want.level);
          if (env_phase !== want.phase) report_mismatch("phase", env_phase, want.phase);
        end
      end
      if (tick_valid && tick_ready) begin
        step_envelope(tick_gate, got);
        predicted_samples.push_back(got);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ATTACK:  attack_len  = pwdata[CW-1:0];
          REG_DECAY:   decay_len   = pwdata[CW-1:0];
          REG_RELEASE: release_len = pwdata[CW-1:0];
          REG_SUSTAIN: sustain_lvl = pwdata[LW-1:0];
          default: ;
        endcase
      end
    end
    pending_results = predicted_samples.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the envelope testbench: clock, reset, register setup, gate stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import lae_pkg::*;

  // The final wait is sized from TICK_LATENCY, the time one ramp tick spends in the block.
  localparam int TICK_LATENCY = 2 * LEVEL_WIDTH_DEF + 2;
  localparam int RANDOM_TICKS = 700;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [COUNT_WIDTH_DEF-1:0] LEN_MAX = {COUNT_WIDTH_DEF{1'b1}};
  localparam logic [LEVEL_WIDTH_DEF-1:0] LVL_MAX = {LEVEL_WIDTH_DEF{1'b1}};

  logic clk;
  logic rst;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  lae_gate_if tick_if ();
  lae_env_if  env_if ();

  int mismatch_count;
  int pending_results;
  int cycle_count;
  int ticks_sent;

  // Idling switches; each phase of the run turns them on or off so that there
  // are stretches with no gaps at all as well as stretches full of them.
  bit tick_gaps;
  bit env_stalls;
  int env_hold;

  linear_adsr_envelope u_dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_if.sink),
    .env     (env_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lae_envelope_checker u_envelope_check (
    .clk             (clk),
    .rst             (rst),
    .tick_valid      (tick_if.valid),
    .tick_ready      (tick_if.ready),
    .tick_gate       (tick_if.gate),
    .env_valid       (env_if.valid),
    .env_ready       (env_if.ready),
    .env_level       (env_if.level),
    .env_phase       (env_if.phase),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  // The run limit stops a hung block; reaching it is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Gap length for either side: mostly none or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // The result side drops ready for random stretches while stalls are enabled.
  always @(negedge clk) begin
    if (env_hold > 0) begin
      env_hold      <= env_hold - 1;
      env_if.ready  <= 1'b0;
    end else if (env_stalls && $urandom_range(0, 3) == 0) begin
      env_hold      <= pick_gap();
      env_if.ready  <= 1'b0;
    end else begin
      env_if.ready  <= 1'b1;
    end
  end

  // One register write: a setup cycle, then an access cycle that completes at the
  // rising edge where pready is seen high.
  task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_WIDTH-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lower the request line and hold off until every predicted sample has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    tick_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // The block is idle here, so all four registers can be rewritten safely.
  task automatic program_envelope(input logic [COUNT_WIDTH_DEF-1:0] attack,
                                  input logic [COUNT_WIDTH_DEF-1:0] decay,
                                  input logic [COUNT_WIDTH_DEF-1:0] rel,
                                  input logic [LEVEL_WIDTH_DEF-1:0] sustain);
    hold_until_drained();
    reg_write(REG_ATTACK, APB_DATA_WIDTH'(attack));
    reg_write(REG_DECAY, APB_DATA_WIDTH'(decay));
    reg_write(REG_RELEASE, APB_DATA_WIDTH'(rel));
    reg_write(REG_SUSTAIN, APB_DATA_WIDTH'(sustain));
  endtask

  // Offer one gate request and return once it has been taken. The valid line is
  // lowered only when a gap is wanted, so back-to-back requests keep it high.
  task automatic send_gate(input logic g);
    int gap;
    gap = tick_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.gate  <= g;
    do @(posedge clk); while (!tick_if.ready);
    ticks_sent++;
  endtask

  task automatic send_run(input logic g, input int count);
    repeat (count) send_gate(g);
  endtask

  // Phase lengths are mostly short so that whole notes run through every phase;
  // zero, the largest count and fully random counts show up now and then.
  function automatic logic [COUNT_WIDTH_DEF-1:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return '0;
      1: return LEN_MAX;
      2: return COUNT_WIDTH_DEF'($urandom_range(0, 32'(LEN_MAX)));
      3: return COUNT_WIDTH_DEF'($urandom_range(13, 300));
      default: return COUNT_WIDTH_DEF'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [LEVEL_WIDTH_DEF-1:0] pick_sustain();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return LVL_MAX;
    return LEVEL_WIDTH_DEF'($urandom_range(0, 32'(LVL_MAX)));
  endfunction

  initial begin
    int setting;
    int burst;
    clk           = 1'b0;
    rst           = 1'b1;
    cycle_count   = 0;
    ticks_sent    = 0;
    tick_gaps     = 1'b0;
    env_stalls    = 1'b0;
    env_hold      = 0;
    tick_if.valid = 1'b0;
    tick_if.gate  = 1'b0;
    env_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. With every register at its reset value of zero, each phase
    // ends on its first tick: idle, attack end, decay end at a zero sustain
    // level, release end, then idle again.
    send_gate(1'b0);
    send_run(1'b1, 2);
    send_run(1'b0, 2);

    // Short ramps: a full note through attack, decay and sustain, a release to
    // idle, a release cut in during attack, and a new attack cut in during release.
    program_envelope(COUNT_WIDTH_DEF'(4), COUNT_WIDTH_DEF'(3), COUNT_WIDTH_DEF'(5),
                     16'h8000);
    send_run(1'b1, 9);
    send_run(1'b0, 6);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 5);
    send_run(1'b0, 1);

    // Random part, one register setting per phase. The first two settings put
    // the largest value in some registers and zero or one in the others, then swap them.
    setting    = 0;
    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      case (setting)
        0: program_envelope('0, LEN_MAX, LEN_MAX, LVL_MAX);
        1: program_envelope(LEN_MAX, COUNT_WIDTH_DEF'(1), COUNT_WIDTH_DEF'(1), '0);
        default: program_envelope(pick_length(), pick_length(), pick_length(),
                                  pick_sustain());
      endcase
      tick_gaps  = $urandom_range(0, 3) != 0;
      env_stalls = $urandom_range(0, 3) != 0;
      for (burst = 0; burst < 6; burst++) begin
        // Once early on, and at random later, the sender waits for every
        // outstanding result before going on.
        if ((setting == 0 && burst == 2) || $urandom_range(0, 29) == 0) hold_until_drained();
        if ($urandom_range(0, 6) == 0) begin
          // Noise: gate flips at random from tick to tick.
          repeat ($urandom_range(1, 10)) send_gate(1'($urandom_range(0, 1)));
        end else begin
          // A well-formed note: held for a while, then released.
          send_run(1'b1, $urandom_range(1, 30));
          send_run(1'b0, $urandom_range(1, 25));
        end
      end
      setting++;
    end

    // Let the last results drain, then allow for a stray extra result.
    hold_until_drained();
    repeat (TICK_LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- linear_adsr_envelope.f -----
hdl/lae_pkg.sv
hdl/lae_if.sv
hdl/linear_adsr_envelope.sv
tb/lae_envelope_checker.sv
tb/testbench.sv
